// File: src/prvu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prvu_pkg: shared types and constants
// Operation codes, controller commands, CORDIC table and saturation helper
// for the polar/rectangular vector unit.
// ---------------------------------------------------------------------------
package prvu_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int GUARD_BITS       = 8;
  localparam int CW               = 48;   // CORDIC datapath width
  localparam int CNT_W            = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;   // 64 quotient bits
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [3:0] {
    MODE_LOAD_RECT    = 4'd0,
    MODE_LOAD_POLAR   = 4'd1,
    MODE_LOAD_DIR_MAG = 4'd2,
    MODE_SET_MAG      = 4'd3,
    MODE_CHANGE_MAG   = 4'd4,
    MODE_SET_ANGLE    = 4'd5,
    MODE_CHANGE_ANGLE = 4'd6,
    MODE_MUL_MAG      = 4'd7,
    MODE_SCALE_ROTATE = 4'd8,
    MODE_ADD          = 4'd9,
    MODE_SUB          = 4'd10,
    MODE_ANGLE_BETWEEN = 4'd11
  } mode_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_ADD, DP_SUB, DP_VEC_INIT, DP_VEC_STEP,
    DP_LEN_A, DP_LEN_B, DP_LEN_FIN, DP_COMMIT_RECT, DP_COMMIT_ANG,
    DP_COMMIT_BETWEEN, DP_ANG_SET, DP_ANG_ADD, DP_PM_AMT, DP_PM_MAG,
    DP_ROT_INIT, DP_ROT_STEP, DP_ROT_FIN, DP_CLEAR, DP_MUL_AMT, DP_MUL_PM,
    DP_MULQ_WR, DP_NM, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_WR, DP_MAG_PM,
    DP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_MAG, SEL_X, SEL_Y, SEL_PM
  } sel_t;

  typedef struct packed {
    dp_op_t     op;
    sel_t       sel;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic pm_le0;
    logic mag_zero;
    logic mag_le0;
    logic amt_le0;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ADDSUB, S_VINIT, S_VSTEP, S_LEN_A, S_LEN_B,
    S_LEN_FIN, S_COMMIT, S_ANG, S_PM, S_SETPOL, S_ROT_INIT, S_ROT_STEP,
    S_ROT_FIN, S_CLEAR, S_MUL, S_MULQ_WR, S_MAG_CHECK, S_NM, S_NM_CHECK,
    S_DIV_INIT, S_DIV_STEP, S_DIV_WR, S_MAG_PM, S_DONE
  } state_t;

  // clamp to signed 32 bits; top bit reports a clamp
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// File: src/prvu_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prvu_datapath: vector state and shared arithmetic
// Holds the vector, runs one CORDIC iteration, one multiply or one divide
// bit per command, and keeps the output word register.
// ---------------------------------------------------------------------------
module prvu_datapath #(
  parameter int FRAC_BITS = prvu_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prvu_pkg::dp_cmd_t    cmd,
  output prvu_pkg::dp_status_t status,
  input  logic [31:0]          x_in,
  input  logic [31:0]          y_in,
  input  logic [31:0]          angle_in,
  input  logic [31:0]          amount_in,
  output logic [31:0]          x_out,
  output logic [31:0]          y_out,
  output logic [31:0]          angle_out,
  output logic [31:0]          magnitude_out,
  output logic [31:0]          between_out,
  output logic                 saturated
);
  import prvu_pkg::*;

  logic signed [31:0] x_reg, y_reg, mag_reg, pm;
  logic        [31:0] angle_reg, between;
  logic signed [31:0] xi, yi, amt, vx, vy;
  logic        [31:0] ai;
  logic               vzero, sat;
  logic signed [CW-1:0] cx, cy;
  logic signed [33:0] cz;
  logic        [63:0] pacc;
  logic        [39:0] len;
  logic signed [63:0] prod;
  logic        [31:0] rem;
  logic        [63:0] quo;
  logic               dneg;

  logic signed [31:0] sel_a, mul_b;
  logic signed [63:0] mul_p, mq;
  logic signed [CW-1:0] sh_x, sh_y, xs, ys, rot_t;
  logic signed [33:0] atan_i;
  logic signed [32:0] ax, ay, nm;
  logic        [32:0] r_ax, r_ay, r_len, r_rx, r_ry, r_mq, r_nm, r_dv;
  logic        [32:0] div_t;
  logic        [31:0] a_fold;
  logic signed [CW-1:0] rx_r, ry_r;

  assign status.pm_le0   = (pm <= 0);
  assign status.mag_zero = (mag_reg == 0);
  assign status.mag_le0  = (mag_reg <= 0);
  assign status.amt_le0  = (amt <= 0);

  always_comb begin
    unique case (cmd.sel)
      SEL_MAG: sel_a = mag_reg;
      SEL_X:   sel_a = x_reg;
      SEL_Y:   sel_a = y_reg;
      default: sel_a = pm;
    endcase
    mul_b  = (cmd.op == DP_MUL_PM) ? pm : amt;
    mul_p  = sel_a * mul_b;
    mq     = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    r_mq   = sat32(65'(mq));
    sh_x   = cx >>> cmd.step;
    sh_y   = cy >>> cmd.step;
    atan_i = $signed({2'b00, ATAN_TAB[cmd.step]});
    xs     = CW'(vx) <<< GUARD_BITS;
    ys     = CW'(vy) <<< GUARD_BITS;
    if (cmd.op == DP_SUB) begin
      ax = 33'(x_reg) - 33'(xi);
      ay = 33'(y_reg) - 33'(yi);
    end else begin
      ax = 33'(x_reg) + 33'(xi);
      ay = 33'(y_reg) + 33'(yi);
    end
    r_ax   = sat32(65'(ax));
    r_ay   = sat32(65'(ay));
    r_len  = sat32($signed({25'd0, len}));
    rot_t  = $signed({1'b0, 46'((61'(pm[30:0]) * 61'(GAIN_Q30))
                                >> (30 - GUARD_BITS)), 1'b0}) >>> 1;
    a_fold = angle_reg + 32'h40000000;
    rx_r   = (cx + (CW'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    ry_r   = (cy + (CW'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    r_rx   = sat32(65'(rx_r));
    r_ry   = sat32(65'(ry_r));
    nm     = 33'(mag_reg) + 33'(amt);
    r_nm   = sat32(65'(nm));
    div_t  = {rem, quo[63]};
    r_dv   = dneg ? sat32(-$signed({1'b0, quo})) : sat32($signed({1'b0, quo}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_reg     <= '0;
      y_reg     <= '0;
      angle_reg <= '0;
      mag_reg   <= '0;
    end else begin
      unique case (cmd.op)
        DP_LATCH: begin
          xi      <= x_in;
          yi      <= y_in;
          ai      <= angle_in;
          amt     <= amount_in;
          vx      <= x_in;
          vy      <= y_in;
          sat     <= 1'b0;
          between <= '0;
        end
        DP_ADD, DP_SUB: begin
          vx  <= r_ax[31:0];
          vy  <= r_ay[31:0];
          sat <= sat | r_ax[32] | r_ay[32];
        end
        DP_VEC_INIT: begin
          vzero <= (vx == 0) && (vy == 0);
          // fold the left half plane onto the right
          if (vx < 0) begin
            cx <= -xs;
            cy <= -ys;
            cz <= 34'h080000000;
          end else begin
            cx <= xs;
            cy <= ys;
            cz <= '0;
          end
        end
        DP_VEC_STEP: begin
          if (!cy[CW-1]) begin
            cx <= cx + sh_y;
            cy <= cy - sh_x;
            cz <= cz + atan_i;
          end else begin
            cx <= cx - sh_y;
            cy <= cy + sh_x;
            cz <= cz - atan_i;
          end
        end
        DP_LEN_A: pacc <= 64'(cx[CW-1:16]) * 64'(GAIN_Q30);
        DP_LEN_B: pacc <= pacc + ((64'(cx[15:0]) * 64'(GAIN_Q30)) >> 16);
        DP_LEN_FIN: len <= 40'((pacc + (64'd1 << (13 + GUARD_BITS))) >> (14 + GUARD_BITS));
        DP_COMMIT_RECT: begin
          x_reg     <= vx;
          y_reg     <= vy;
          angle_reg <= vzero ? '0 : cz[31:0];
          mag_reg   <= vzero ? '0 : r_len[31:0];
          sat       <= sat | (!vzero & r_len[32]);
        end
        DP_COMMIT_ANG: angle_reg <= vzero ? '0 : cz[31:0];
        DP_COMMIT_BETWEEN: between <= (vzero ? 32'd0 : cz[31:0]) - angle_reg;
        DP_ANG_SET: angle_reg <= ai;
        DP_ANG_ADD: angle_reg <= angle_reg + ai;
        DP_PM_AMT:  pm <= amt;
        DP_PM_MAG:  pm <= mag_reg;
        DP_ROT_INIT: begin
          mag_reg <= pm;
          cy      <= '0;
          // fold the back half turn onto the front
          if (a_fold[31]) begin
            cx <= -rot_t;
            cz <= 34'($signed(angle_reg ^ 32'h80000000));
          end else begin
            cx <= rot_t;
            cz <= 34'($signed(angle_reg));
          end
        end
        DP_ROT_STEP: begin
          if (!cz[33]) begin
            cx <= cx - sh_y;
            cy <= cy + sh_x;
            cz <= cz - atan_i;
          end else begin
            cx <= cx + sh_y;
            cy <= cy - sh_x;
            cz <= cz + atan_i;
          end
        end
        DP_ROT_FIN: begin
          x_reg <= r_rx[31:0];
          y_reg <= r_ry[31:0];
          sat   <= sat | r_rx[32] | r_ry[32];
        end
        DP_CLEAR: begin
          x_reg   <= '0;
          y_reg   <= '0;
          mag_reg <= '0;
        end
        DP_MUL_AMT, DP_MUL_PM: prod <= mul_p;
        DP_MULQ_WR: begin
          sat <= sat | r_mq[32];
          unique case (cmd.sel)
            SEL_MAG: mag_reg <= r_mq[31:0];
            SEL_X:   x_reg   <= r_mq[31:0];
            SEL_Y:   y_reg   <= r_mq[31:0];
            default: pm      <= r_mq[31:0];
          endcase
        end
        DP_NM: begin
          pm  <= r_nm[31:0];
          sat <= sat | r_nm[32];
        end
        DP_DIV_INIT: begin
          dneg <= prod[63];
          quo  <= prod[63] ? 64'(-prod) : 64'(prod);
          rem  <= '0;
        end
        DP_DIV_STEP: begin
          if (div_t >= {1'b0, mag_reg}) begin
            rem <= 32'(div_t - {1'b0, mag_reg});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= div_t[31:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        DP_DIV_WR: begin
          sat <= sat | r_dv[32];
          if (cmd.sel == SEL_X) begin
            x_reg <= r_dv[31:0];
          end else begin
            y_reg <= r_dv[31:0];
          end
        end
        DP_MAG_PM: mag_reg <= pm;
        DP_OUT_LOAD: begin
          x_out         <= x_reg;
          y_out         <= y_reg;
          angle_out     <= angle_reg;
          magnitude_out <= mag_reg;
          between_out   <= between;
          saturated     <= sat;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/prvu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prvu_ctrl: operation sequencer
// Steps through the command sequence of each mode and owns both handshakes.
// ---------------------------------------------------------------------------
module prvu_ctrl #(
  parameter int CORDIC_STEPS = prvu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prvu_pkg::dp_cmd_t    cmd,
  input  prvu_pkg::dp_status_t status
);
  import prvu_pkg::*;

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_t            state, state_next;
  logic [3:0]        mode_reg;
  logic [CNT_W-1:0]  cnt, cnt_next;
  sel_t              tgt, tgt_next;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      tgt       <= SEL_MAG;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      tgt   <= tgt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (state == S_IDLE) begin
      mode_reg <= mode;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    tgt_next   = tgt;
    out_load   = 1'b0;
    cmd.op     = DP_NOP;
    cmd.sel    = tgt;
    cmd.step   = cnt[4:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (mode_reg)
          MODE_LOAD_RECT, MODE_LOAD_DIR_MAG, MODE_ANGLE_BETWEEN: state_next = S_VINIT;
          MODE_ADD, MODE_SUB: state_next = S_ADDSUB;
          MODE_LOAD_POLAR, MODE_SET_ANGLE, MODE_CHANGE_ANGLE, MODE_SCALE_ROTATE:
            state_next = S_ANG;
          MODE_SET_MAG: state_next = S_PM;
          MODE_CHANGE_MAG: state_next = status.mag_zero ? S_PM : S_NM;
          MODE_MUL_MAG: begin
            tgt_next   = SEL_MAG;
            state_next = status.amt_le0 ? S_CLEAR : S_MUL;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ADDSUB: begin
        cmd.op     = (mode_reg == MODE_SUB) ? DP_SUB : DP_ADD;
        state_next = S_VINIT;
      end
      S_VINIT: begin
        cmd.op     = DP_VEC_INIT;
        cnt_next   = '0;
        state_next = S_VSTEP;
      end
      S_VSTEP: begin
        cmd.op   = DP_VEC_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CORDIC_LAST) begin
          state_next = (mode_reg == MODE_LOAD_DIR_MAG || mode_reg == MODE_ANGLE_BETWEEN)
                       ? S_COMMIT : S_LEN_A;
        end
      end
      S_LEN_A: begin
        cmd.op     = DP_LEN_A;
        state_next = S_LEN_B;
      end
      S_LEN_B: begin
        cmd.op     = DP_LEN_B;
        state_next = S_LEN_FIN;
      end
      S_LEN_FIN: begin
        cmd.op     = DP_LEN_FIN;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (mode_reg == MODE_LOAD_DIR_MAG) begin
          cmd.op     = DP_COMMIT_ANG;
          state_next = S_PM;
        end else if (mode_reg == MODE_ANGLE_BETWEEN) begin
          cmd.op     = DP_COMMIT_BETWEEN;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_COMMIT_RECT;
          state_next = S_DONE;
        end
      end
      S_ANG: begin
        cmd.op = (mode_reg == MODE_LOAD_POLAR || mode_reg == MODE_SET_ANGLE)
                 ? DP_ANG_SET : DP_ANG_ADD;
        if (mode_reg == MODE_SCALE_ROTATE) begin
          tgt_next   = SEL_MAG;
          state_next = S_MUL;
        end else begin
          state_next = S_PM;
        end
      end
      S_PM: begin
        cmd.op = (mode_reg == MODE_SET_ANGLE || mode_reg == MODE_CHANGE_ANGLE)
                 ? DP_PM_MAG : DP_PM_AMT;
        state_next = S_SETPOL;
      end
      S_SETPOL: state_next = status.pm_le0 ? S_CLEAR : S_ROT_INIT;
      S_ROT_INIT: begin
        cmd.op     = DP_ROT_INIT;
        cnt_next   = '0;
        state_next = S_ROT_STEP;
      end
      S_ROT_STEP: begin
        cmd.op   = DP_ROT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_ROT_FIN;
        end
      end
      S_ROT_FIN: begin
        cmd.op     = DP_ROT_FIN;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.op     = DP_CLEAR;
        state_next = S_DONE;
      end
      S_MUL: begin
        if (mode_reg == MODE_CHANGE_MAG) begin
          cmd.op     = DP_MUL_PM;
          state_next = S_DIV_INIT;
        end else begin
          cmd.op     = DP_MUL_AMT;
          state_next = S_MULQ_WR;
        end
      end
      S_MULQ_WR: begin
        cmd.op = DP_MULQ_WR;
        if (mode_reg == MODE_SCALE_ROTATE) begin
          cmd.sel    = SEL_PM;
          state_next = S_SETPOL;
        end else begin
          unique case (tgt)
            SEL_MAG: begin
              tgt_next   = SEL_X;
              state_next = S_MUL;
            end
            SEL_X: begin
              tgt_next   = SEL_Y;
              state_next = S_MUL;
            end
            default: state_next = S_MAG_CHECK;
          endcase
        end
      end
      S_MAG_CHECK: state_next = status.mag_le0 ? S_CLEAR : S_DONE;
      S_NM: begin
        cmd.op     = DP_NM;
        state_next = S_NM_CHECK;
      end
      S_NM_CHECK: begin
        tgt_next   = SEL_X;
        state_next = status.pm_le0 ? S_CLEAR : S_MUL;
      end
      S_DIV_INIT: begin
        cmd.op     = DP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op   = DP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_DIV_WR;
        end
      end
      S_DIV_WR: begin
        cmd.op = DP_DIV_WR;
        if (tgt == SEL_X) begin
          tgt_next   = SEL_Y;
          state_next = S_MUL;
        end else begin
          state_next = S_MAG_PM;
        end
      end
      S_MAG_PM: begin
        cmd.op     = DP_MAG_PM;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.op     = DP_OUT_LOAD;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/polar_rect_vector_unit_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polar_rect_vector_unit_top: polar/rectangular vector unit
// Keeps one 2D vector in both forms and applies one operation per word.
// ---------------------------------------------------------------------------
// One word at a time runs through a sequencer over a shared CORDIC stage,
// one 32x32 multiplier and a one-bit-per-cycle divider. Load rect, add,
// sub, angle between, load polar, set magnitude, the angle changes and
// scale-rotate each make one CORDIC pass; load_dir_mag makes a vectoring
// pass then a rotation pass; mul_mag uses the multiplier; change_mag with a
// nonzero magnitude runs two 64-step divides.
// The next word is taken while a finished result waits in the output
// register.
module polar_rect_vector_unit_top #(
  parameter int CORDIC_STEPS = prvu_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = prvu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [31:0] x_in,
  input  logic [31:0] y_in,
  input  logic [31:0] angle_in,
  input  logic [31:0] amount_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] x_out,
  output logic [31:0] y_out,
  output logic [31:0] angle_out,
  output logic [31:0] magnitude_out,
  output logic [31:0] between_out,
  output logic        saturated
);
  import prvu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  prvu_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  prvu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .x_in          (x_in),
    .y_in          (y_in),
    .angle_in      (angle_in),
    .amount_in     (amount_in),
    .x_out         (x_out),
    .y_out         (y_out),
    .angle_out     (angle_out),
    .magnitude_out (magnitude_out),
    .between_out   (between_out),
    .saturated     (saturated)
  );

endmodule
